/* rtl/prxyz_pkg.sv */
// ----------------------------------------------------------------------------
// prxyz_pkg
// shared types and constants for the xyz point rotation pipeline
// ----------------------------------------------------------------------------
package prxyz_pkg;

    // coefficient registers are written through a 16-bit signed field
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_X   = 3'd0,
        CFG_SIN_X   = 3'd1,
        CFG_COS_Y   = 3'd2,
        CFG_SIN_Y   = 3'd3,
        CFG_COS_Z   = 3'd4,
        CFG_SIN_Z   = 3'd5,
        CFG_PIVOT_X = 3'd6,
        CFG_PIVOT_Y = 3'd7
    } t_cfg_reg;

    // stage enables of one row unit, plus the sign of its second product
    typedef struct packed {
        logic en_mul;
        logic en_sum;
        logic en_sat;
        logic sub;
    } t_row_ctl;

endpackage

/* rtl/point_rotate_xyz_about_pivot.sv */
// ----------------------------------------------------------------------------
// point_rotate_xyz_about_pivot
// rotates a 3d point about x, then y, then z around an xy pivot
// ----------------------------------------------------------------------------
// Takes one point per clock unless the output stalls and returns its
// rotated x and y: each of the three rotations is four register stages
// (pivot subtract, coefficient multiply, sum and floor shift, pivot add
// with saturation). Bubbles collapse, so a stalled output only holds back
// the input once every stage is full; the input side then takes a new
// request as soon as the output register is read. Coordinates are signed
// with COORD_WIDTH bits (Q16.16 by default), coefficients are Q2.14 and
// configuration should only be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module point_rotate_xyz_about_pivot #(
    parameter int COORD_WIDTH    = 32,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // config write port
    input  logic                                    i_cfg_we,
    input  logic [prxyz_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]                  i_cfg_wdata,
    // point input: px, py, pz from bit 0 up
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      i_s_tdata,
    // rotated output: out_x, out_y from bit 0 up
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      o_m_tdata
);

    localparam int W     = COORD_WIDTH;
    localparam int F     = COEF_FRAC_BITS;
    localparam int KW    = (F + 2 > prxyz_pkg::COEF_W) ? F + 2 : prxyz_pkg::COEF_W;
    localparam int OW    = ((2*COORD_WIDTH+7)/8)*8;
    localparam int NSTG  = 12;
    localparam logic signed [KW-1:0] ONE_COEF = KW'(64'd1 << F);

    // configuration
    logic signed [KW-1:0] r_cos_x, r_sin_x, r_cos_y, r_sin_y, r_cos_z, r_sin_z;
    logic signed [W-1:0]  r_pivot_x, r_pivot_y;
    logic signed [KW-1:0] n_coef;

    assign n_coef = KW'($signed(i_cfg_wdata[prxyz_pkg::COEF_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_x   <= ONE_COEF;
            r_sin_x   <= '0;
            r_cos_y   <= ONE_COEF;
            r_sin_y   <= '0;
            r_cos_z   <= ONE_COEF;
            r_sin_z   <= '0;
            r_pivot_x <= '0;
            r_pivot_y <= '0;
        end else if (i_cfg_we) begin
            case (prxyz_pkg::t_cfg_reg'(i_cfg_idx))
                prxyz_pkg::CFG_COS_X:   r_cos_x   <= n_coef;
                prxyz_pkg::CFG_SIN_X:   r_sin_x   <= n_coef;
                prxyz_pkg::CFG_COS_Y:   r_cos_y   <= n_coef;
                prxyz_pkg::CFG_SIN_Y:   r_sin_y   <= n_coef;
                prxyz_pkg::CFG_COS_Z:   r_cos_z   <= n_coef;
                prxyz_pkg::CFG_SIN_Z:   r_sin_z   <= n_coef;
                prxyz_pkg::CFG_PIVOT_X: r_pivot_x <= $signed(i_cfg_wdata);
                prxyz_pkg::CFG_PIVOT_Y: r_pivot_y <= $signed(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    // valid bits and per-stage enables, bubbles collapse
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || i_m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_v[NSTG-1];

    // stage 0: take the point, offset y for the x rotation
    logic signed [W-1:0] in_x, in_y, in_z;
    logic signed [W-1:0] r0_x, r0_z;
    logic signed [W:0]   r0_dy;

    assign in_x = $signed(i_s_tdata[W-1:0]);
    assign in_y = $signed(i_s_tdata[2*W-1:W]);
    assign in_z = $signed(i_s_tdata[3*W-1:2*W]);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_x  <= in_x;
            r0_z  <= in_z;
            r0_dy <= (W+1)'(in_y) - (W+1)'(r_pivot_y);
        end
    end

    // rotation about x: x is unchanged, stages 1..3
    prxyz_pkg::t_row_ctl ctl_x_add, ctl_x_sub;
    logic signed [W-1:0] y1, z1;
    logic signed [W-1:0] r_xd [1:3];

    assign ctl_x_sub = '{en_mul: en[1], en_sum: en[2], en_sat: en[3], sub: 1'b1};
    assign ctl_x_add = '{en_mul: en[1], en_sum: en[2], en_sat: en[3], sub: 1'b0};

    prxyz_row #(.W(W), .F(F), .KW(KW)) u_row_xy (
        .i_clk (i_clk),
        .i_ctl (ctl_x_sub),
        .i_a   (r0_dy),
        .i_ka  (r_cos_x),
        .i_b   ((W+1)'(r0_z)),
        .i_kb  (r_sin_x),
        .i_off (r_pivot_y),
        .o_res (y1)
    );

    prxyz_row #(.W(W), .F(F), .KW(KW)) u_row_xz (
        .i_clk (i_clk),
        .i_ctl (ctl_x_add),
        .i_a   (r0_dy),
        .i_ka  (r_sin_x),
        .i_b   ((W+1)'(r0_z)),
        .i_kb  (r_cos_x),
        .i_off ('0),
        .o_res (z1)
    );

    always_ff @(posedge i_clk) begin
        if (en[1]) r_xd[1] <= r0_x;
        if (en[2]) r_xd[2] <= r_xd[1];
        if (en[3]) r_xd[3] <= r_xd[2];
    end

    // stage 4: offset x for the y rotation; y passes, z only feeds x
    logic signed [W:0]   r4_dx;
    logic signed [W-1:0] r4_y, r4_z;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_dx <= (W+1)'(r_xd[3]) - (W+1)'(r_pivot_x);
            r4_y  <= y1;
            r4_z  <= z1;
        end
    end

    prxyz_pkg::t_row_ctl ctl_y;
    logic signed [W-1:0] x2;
    logic signed [W-1:0] r_yd [5:7];

    assign ctl_y = '{en_mul: en[5], en_sum: en[6], en_sat: en[7], sub: 1'b0};

    prxyz_row #(.W(W), .F(F), .KW(KW)) u_row_yx (
        .i_clk (i_clk),
        .i_ctl (ctl_y),
        .i_a   (r4_dx),
        .i_ka  (r_cos_y),
        .i_b   ((W+1)'(r4_z)),
        .i_kb  (r_sin_y),
        .i_off (r_pivot_x),
        .o_res (x2)
    );

    always_ff @(posedge i_clk) begin
        if (en[5]) r_yd[5] <= r4_y;
        if (en[6]) r_yd[6] <= r_yd[5];
        if (en[7]) r_yd[7] <= r_yd[6];
    end

    // stage 8: offset x and y for the z rotation
    logic signed [W:0] r8_dx, r8_dy;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r8_dx <= (W+1)'(x2) - (W+1)'(r_pivot_x);
            r8_dy <= (W+1)'(r_yd[7]) - (W+1)'(r_pivot_y);
        end
    end

    prxyz_pkg::t_row_ctl ctl_z_add, ctl_z_sub;
    logic signed [W-1:0] x3, y3;

    assign ctl_z_sub = '{en_mul: en[9], en_sum: en[10], en_sat: en[11], sub: 1'b1};
    assign ctl_z_add = '{en_mul: en[9], en_sum: en[10], en_sat: en[11], sub: 1'b0};

    prxyz_row #(.W(W), .F(F), .KW(KW)) u_row_zx (
        .i_clk (i_clk),
        .i_ctl (ctl_z_sub),
        .i_a   (r8_dx),
        .i_ka  (r_cos_z),
        .i_b   (r8_dy),
        .i_kb  (r_sin_z),
        .i_off (r_pivot_x),
        .o_res (x3)
    );

    prxyz_row #(.W(W), .F(F), .KW(KW)) u_row_zy (
        .i_clk (i_clk),
        .i_ctl (ctl_z_add),
        .i_a   (r8_dx),
        .i_ka  (r_sin_z),
        .i_b   (r8_dy),
        .i_kb  (r_cos_z),
        .i_off (r_pivot_y),
        .o_res (y3)
    );

    // the saturating stage of the z rows is the output register
    assign o_m_tdata = OW'({y3, x3});

endmodule

/* rtl/prxyz_row.sv */
// ----------------------------------------------------------------------------
// prxyz_row
// one matrix row: floor((a*ka +/- b*kb) / 2^F) + off, saturated, three stages
// ----------------------------------------------------------------------------
module prxyz_row #(
    parameter int W  = 32,
    parameter int F  = 14,
    parameter int KW = 16
) (
    input  logic                    i_clk,
    input  prxyz_pkg::t_row_ctl     i_ctl,
    input  logic signed [W:0]       i_a,
    input  logic signed [KW-1:0]    i_ka,
    input  logic signed [W:0]       i_b,
    input  logic signed [KW-1:0]    i_kb,
    input  logic signed [W-1:0]     i_off,
    output logic signed [W-1:0]     o_res
);

    localparam int PW = W + 1 + KW;
    localparam int SW = PW + 1;
    localparam int TW = SW + 1;
    localparam logic signed [TW-1:0] SAT_MAX = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_MIN = {{(TW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic signed [PW-1:0] r_pa;
    logic signed [PW-1:0] r_pb;
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_full;
    logic signed [TW-1:0] n_tot;
    logic signed [W-1:0]  r_res;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_pa <= PW'(i_a) * PW'(i_ka);
            r_pb <= PW'(i_b) * PW'(i_kb);
        end
    end

    always_comb begin
        if (i_ctl.sub) begin
            n_full = SW'(r_pa) - SW'(r_pb);
        end else begin
            n_full = SW'(r_pa) + SW'(r_pb);
        end
    end

    // arithmetic shift is the floor of the exact sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_sum <= n_full >>> F;
        end
    end

    assign n_tot = TW'(r_sum) + TW'(i_off);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sat) begin
            if (n_tot > SAT_MAX) begin
                r_res <= SAT_MAX[W-1:0];
            end else if (n_tot < SAT_MIN) begin
                r_res <= SAT_MIN[W-1:0];
            end else begin
                r_res <= n_tot[W-1:0];
            end
        end
    end

    assign o_res = r_res;

endmodule
